### hdl/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Item structs, command codes, character codes and state encodings.
// ---------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // attribute after reset, and the blank cell the screen starts with
    localparam logic [7:0]  COLOR_RESET = 8'h07;
    localparam logic [15:0] BLANK_RESET = {COLOR_RESET, CH_SPACE};

    // tab stops every TAB_STEP columns (power of two)
    localparam int TAB_STEP = 4;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] cell_value;
        logic        scrolled;
    } t_out_item;

    // request from the command sequencer to the buffer sweeper
    typedef struct packed {
        logic        start;
        logic        scroll;   // 1: move rows up then blank last row, 0: blank all
        logic [15:0] blank;
    } t_sweep_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_PUSH
    } t_state;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_COPY,
        SW_FILL
    } t_sw_state;

endpackage

### hdl/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/tcw_sweep.sv
// ---------------------------------------------------------------------------
// tcw_sweep: screen buffer sweeper
// Walks the cell buffer one entry a cycle: blank fill of the whole screen,
// or scroll (copy every row up by one, then blank the last row).
// ---------------------------------------------------------------------------
module tcw_sweep #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int AW     = $clog2(CELLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_sweep_cmd i_cmd,
    input  logic [15:0]         i_rd_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [15:0]         o_wr_data,
    output logic                o_done
);

    localparam logic [AW-1:0] ColsA   = AW'(COLUMNS);
    localparam logic [AW-1:0] CopyEnd = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LastA   = AW'(CELLS - 1);

    tcw_pkg::t_sw_state r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_wa, n_wa;
    logic               r_pend, n_pend;
    logic [15:0]        r_blank;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::SW_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.scroll ? tcw_pkg::SW_COPY : tcw_pkg::SW_FILL;
                end
            end
            tcw_pkg::SW_COPY: begin
                if (r_idx == CopyEnd) begin
                    n_state = tcw_pkg::SW_FILL;
                end
            end
            tcw_pkg::SW_FILL: begin
                if (r_idx == LastA) begin
                    n_state = tcw_pkg::SW_IDLE;
                end
            end
            default: n_state = tcw_pkg::SW_IDLE;
        endcase
    end

    // memory requests and counters
    always_comb begin
        n_idx     = r_idx;
        n_wa      = r_wa;
        n_pend    = r_pend;
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx + ColsA;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wa;
        o_wr_data = i_rd_data;
        o_done    = 1'b0;
        unique case (r_state)
            tcw_pkg::SW_IDLE: begin
                n_idx  = '0;
                n_pend = 1'b0;
            end
            tcw_pkg::SW_COPY: begin
                // write back the row below, fetched last cycle
                o_wr_en = r_pend;
                if (r_idx != CopyEnd) begin
                    o_rd_en = 1'b1;
                    n_wa    = r_idx;
                    n_pend  = 1'b1;
                    n_idx   = r_idx + AW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            tcw_pkg::SW_FILL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = r_blank;
                if (r_idx == LastA) begin
                    o_done = 1'b1;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::SW_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    // payload: pending write address and latched blank value
    always_ff @(posedge i_clk) begin
        r_wa <= n_wa;
        if (r_state == tcw_pkg::SW_IDLE && i_cmd.start) begin
            r_blank <= i_cmd.blank;
        end
    end

endmodule

### hdl/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// ROWS x COLUMNS buffer of 16-bit cells with a cursor; put char, clear,
// set cursor and read cell commands.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one command
//   item; output channel (o_out_valid / i_out_ready / o_out_item) returns one
//   result item per command, in order. Config channel (i_cfg_valid /
//   o_cfg_ready / i_cfg_data) sets the attribute byte and is always ready.
//   The user must write it only while no command is in flight (not enforced).
//   From acceptance to the output register, by command (no new command is
//   taken until then): put char / set cursor / control chars go straight to
//   the push state; read cell passes the read state, which takes the
//   registered RAM data; clear screen passes the sweep state (blank fill);
//   any put char that scrolls passes the sweep state (copy, then blank fill).
//   Clear and scroll are done by the sweeper walking the cell RAM one entry
//   per cycle; the single RAM write port bounds its pace.
//   After reset the whole buffer is filled with blanks (0x0720); o_in_ready
//   stays low meanwhile.
//   A result waits in the output register while the receiver stalls; the
//   next item is still taken and worked on, and its result is held until the
//   output register frees up.
// ---------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcw_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tcw_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] ColsA   = AW'(COLUMNS);
    localparam logic [RW-1:0] LastRow = RW'(ROWS - 1);
    localparam logic [CW-1:0] LastCol = CW'(COLUMNS - 1);
    localparam logic [CW:0]   TabMask = ~(CW+1)'(tcw_pkg::TAB_STEP - 1);

    tcw_pkg::t_state    r_state, n_state;
    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [7:0]         r_color;
    tcw_pkg::t_out_item r_res, n_res;
    tcw_pkg::t_out_item r_out_item;
    logic               r_out_valid;

    logic               accept;
    logic               out_free;
    logic [RW-1:0]      tgt_row;
    logic [CW-1:0]      tgt_col;
    logic [RW:0]        row_inc;
    logic               row_wraps;
    logic [RW-1:0]      nl_row;
    logic [CW:0]        col_inc;
    logic [CW:0]        col_tab;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      tgt_addr;
    logic [15:0]        put_cell;

    // top-side RAM requests
    logic               top_wr_en;
    logic               top_rd_en;

    tcw_pkg::t_sweep_cmd sw_cmd;
    logic                sw_rd_en;
    logic [AW-1:0]       sw_rd_addr;
    logic                sw_wr_en;
    logic [AW-1:0]       sw_wr_addr;
    logic [15:0]         sw_wr_data;
    logic                sw_done;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [15:0]         ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [15:0]         ram_rd_data;

    assign o_in_ready  = (r_state == tcw_pkg::ST_IDLE);
    assign accept      = i_in_valid & o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    // clamp targets to the screen
    assign tgt_row = (i_in_item.target_row >= 8'(ROWS)) ? LastRow
                                                        : i_in_item.target_row[RW-1:0];
    assign tgt_col = (i_in_item.target_col >= 8'(COLUMNS)) ? LastCol
                                                           : i_in_item.target_col[CW-1:0];

    // cursor arithmetic
    assign row_inc   = {1'b0, r_row} + (RW+1)'(1);
    assign row_wraps = (row_inc >= (RW+1)'(ROWS));
    assign nl_row    = row_wraps ? LastRow : row_inc[RW-1:0];
    assign col_inc   = {1'b0, r_col} + (CW+1)'(1);
    assign col_tab   = ({1'b0, r_col} + (CW+1)'(tcw_pkg::TAB_STEP)) & TabMask;

    // cell addresses: row * COLUMNS + col
    assign cur_addr = AW'(r_row) * ColsA + AW'(r_col);
    assign tgt_addr = AW'(tgt_row) * ColsA + AW'(tgt_col);
    assign put_cell = {r_color, i_in_item.char_code};

    // command decode and cursor update
    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_res     = r_res;
        top_wr_en = 1'b0;
        top_rd_en = 1'b0;
        sw_cmd    = '0;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                sw_cmd.start = 1'b1;
                sw_cmd.blank = tcw_pkg::BLANK_RESET;
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_res.cell_value = '0;
                    n_res.scrolled   = 1'b0;
                    unique case (i_in_item.command)
                        tcw_pkg::CMD_PUT: begin
                            priority if (i_in_item.char_code == tcw_pkg::CH_NEWLINE) begin
                                n_col          = '0;
                                n_row          = nl_row;
                                n_res.scrolled = row_wraps;
                            end else if (i_in_item.char_code == tcw_pkg::CH_RETURN) begin
                                n_col = '0;
                            end else if (i_in_item.char_code == tcw_pkg::CH_TAB) begin
                                if (col_tab >= (CW+1)'(COLUMNS)) begin
                                    n_col          = '0;
                                    n_row          = nl_row;
                                    n_res.scrolled = row_wraps;
                                end else begin
                                    n_col = col_tab[CW-1:0];
                                end
                            end else begin
                                top_wr_en        = 1'b1;
                                n_res.cell_value = put_cell;
                                if (col_inc >= (CW+1)'(COLUMNS)) begin
                                    n_col          = '0;
                                    n_row          = nl_row;
                                    n_res.scrolled = row_wraps;
                                end else begin
                                    n_col = col_inc[CW-1:0];
                                end
                            end
                            sw_cmd.start  = n_res.scrolled;
                            sw_cmd.scroll = 1'b1;
                            sw_cmd.blank  = {r_color, tcw_pkg::CH_SPACE};
                        end
                        tcw_pkg::CMD_CLEAR: begin
                            n_row         = '0;
                            n_col         = '0;
                            sw_cmd.start  = 1'b1;
                            sw_cmd.blank  = {r_color, tcw_pkg::CH_SPACE};
                        end
                        tcw_pkg::CMD_SET: begin
                            n_row = tgt_row;
                            n_col = tgt_col;
                        end
                        tcw_pkg::CMD_READ: begin
                            top_rd_en = 1'b1;
                        end
                        default: ;
                    endcase
                    n_res.cursor_row = 5'(n_row);
                    n_res.cursor_col = 7'(n_col);
                end
            end
            tcw_pkg::ST_READ: begin
                n_res.cell_value = ram_rd_data;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_INIT: n_state = tcw_pkg::ST_INIT_WAIT;
            tcw_pkg::ST_INIT_WAIT: begin
                if (sw_done) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in_item.command == tcw_pkg::CMD_READ) begin
                        n_state = tcw_pkg::ST_READ;
                    end else if (sw_cmd.start) begin
                        n_state = tcw_pkg::ST_SWEEP;
                    end else begin
                        n_state = tcw_pkg::ST_PUSH;
                    end
                end
            end
            tcw_pkg::ST_READ: n_state = tcw_pkg::ST_PUSH;
            tcw_pkg::ST_SWEEP: begin
                if (sw_done) begin
                    n_state = tcw_pkg::ST_PUSH;
                end
            end
            tcw_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_INIT;
        endcase
    end

    // RAM port arbitration: top owns the ports only while idle
    always_comb begin
        if (r_state == tcw_pkg::ST_IDLE) begin
            ram_wr_en   = top_wr_en;
            ram_wr_addr = cur_addr;
            ram_wr_data = put_cell;
            ram_rd_en   = top_rd_en;
            ram_rd_addr = tgt_addr;
        end else begin
            ram_wr_en   = sw_wr_en;
            ram_wr_addr = sw_wr_addr;
            ram_wr_data = sw_wr_data;
            ram_rd_en   = sw_rd_en;
            ram_rd_addr = sw_rd_addr;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_color     <= tcw_pkg::COLOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
            if (r_state == tcw_pkg::ST_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_state == tcw_pkg::ST_PUSH && out_free) begin
            r_out_item <= r_res;
        end
    end

    tcw_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_sweep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (sw_cmd),
        .i_rd_data (ram_rd_data),
        .o_rd_en   (sw_rd_en),
        .o_rd_addr (sw_rd_addr),
        .o_wr_en   (sw_wr_en),
        .o_wr_addr (sw_wr_addr),
        .o_wr_data (sw_wr_data),
        .o_done    (sw_done)
    );

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for text_console_writer
// Drives console commands (put char, clear, set cursor, read cell) over the
// valid/ready input channel, changes the attribute byte between phases, and
// checks every result item against a behavioral screen/cursor predictor.
// Directed items cover the controls, clamping, wrap and scroll. Random
// phases mix text lines with commands under several idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Scroll or clear walks the whole buffer, and so does the fill after
    // reset. The limit is several times the slowest quiet stretch.
    localparam int QUIET_LIMIT  = 20000;
    localparam int PHASE_QUOTA  = 332;
    localparam int SETTLE_TICKS = 8;

    // Screen and cursor predictor with a queue of expected results
    class console_scoreboard;
        localparam int NCOLS = COLUMNS_DEF;
        localparam int NROWS = ROWS_DEF;

        logic [15:0] screen [NROWS*NCOLS];
        int unsigned row_pos;
        int unsigned col_pos;
        logic [7:0]  attr;
        t_out_item   awaiting [$];
        int errors, n_checked, n_scrolls, n_colors;
        int n_puts, n_clears, n_sets, n_reads;

        function new();
            foreach (screen[i]) screen[i] = BLANK_RESET;
            row_pos   = 0;
            col_pos   = 0;
            attr      = COLOR_RESET;
            errors    = 0;
            n_checked = 0;
            n_scrolls = 0;
            n_colors  = 0;
            n_puts    = 0;
            n_clears  = 0;
            n_sets    = 0;
            n_reads   = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        function void note_attr(input logic [7:0] c);
            attr = c;
            n_colors++;
        endfunction

        // Start of next row; past the bottom the screen moves up one row
        function bit line_feed();
            col_pos = 0;
            row_pos++;
            if (row_pos < NROWS) return 1'b0;
            for (int i = 0; i < (NROWS-1)*NCOLS; i++) screen[i] = screen[i+NCOLS];
            for (int i = (NROWS-1)*NCOLS; i < NROWS*NCOLS; i++) screen[i] = {attr, CH_SPACE};
            row_pos = NROWS - 1;
            n_scrolls++;
            return 1'b1;
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void note_command(input t_in_item it);
            t_out_item   want;
            int unsigned trow;
            int unsigned tcol;
            trow = (it.target_row >= NROWS) ? NROWS - 1 : 32'(it.target_row);
            tcol = (it.target_col >= NCOLS) ? NCOLS - 1 : 32'(it.target_col);
            want = '0;
            case (it.command)
                CMD_PUT: begin
                    n_puts++;
                    if (it.char_code == CH_NEWLINE) begin
                        want.scrolled = line_feed();
                    end else if (it.char_code == CH_RETURN) begin
                        col_pos = 0;
                    end else if (it.char_code == CH_TAB) begin
                        col_pos = (col_pos + TAB_STEP) & ~(TAB_STEP - 1);
                        if (col_pos >= NCOLS) want.scrolled = line_feed();
                    end else begin
                        want.cell_value = {attr, it.char_code};
                        screen[row_pos*NCOLS + col_pos] = want.cell_value;
                        col_pos++;
                        if (col_pos >= NCOLS) want.scrolled = line_feed();
                    end
                end
                CMD_CLEAR: begin
                    n_clears++;
                    foreach (screen[i]) screen[i] = {attr, CH_SPACE};
                    row_pos = 0;
                    col_pos = 0;
                end
                CMD_SET: begin
                    n_sets++;
                    row_pos = trow;
                    col_pos = tcol;
                end
                default: begin
                    n_reads++;
                    want.cell_value = screen[trow*NCOLS + tcol];
                end
            endcase
            want.cursor_row = row_pos[4:0];
            want.cursor_col = col_pos[6:0];
            awaiting.push_back(want);
        endfunction

        // Compare one accepted result with the oldest expectation
        task check_result(input t_out_item got);
            t_out_item want;
            if (awaiting.size() == 0) begin
                report($sformatf("result %h arrived with no command pending", got));
                return;
            end
            want = awaiting.pop_front();
            n_checked++;
            if (got.cursor_row !== want.cursor_row)
                report($sformatf("result %0d cursor_row %0d, expected %0d",
                                 n_checked, got.cursor_row, want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report($sformatf("result %0d cursor_col %0d, expected %0d",
                                 n_checked, got.cursor_col, want.cursor_col));
            if (got.cell_value !== want.cell_value)
                report($sformatf("result %0d cell_value %h, expected %h",
                                 n_checked, got.cell_value, want.cell_value));
            if (got.scrolled !== want.scrolled)
                report($sformatf("result %0d scrolled %b, expected %b",
                                 n_checked, got.scrolled, want.scrolled));
        endtask
    endclass

    logic       i_clk     = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = '0;
    logic       in_ready;
    logic       out_valid;
    logic       cfg_ready;
    t_out_item  out_item;

    console_scoreboard sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int n_sent    = 0;
    int quiet     = 0;

    text_console_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_item);
    end

    // Watchdog: ends the run after too long without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one item, with random sender gaps, and hold it until accepted.
    // Valid stays high afterwards; the next caller lowers it or reuses it.
    task automatic send_item(input t_cmd cmd, input logic [7:0] ch,
                             input logic [7:0] r, input logic [7:0] c);
        t_in_item it;
        it.command    = cmd;
        it.char_code  = ch;
        it.target_row = r;
        it.target_col = c;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        sb.note_command(it);
        n_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.awaiting.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [7:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        sb.note_attr(c);
        cfg_valid <= 1'b0;
    endtask

    // Row/column picks: full byte range (clamping), near the far edge, or in range
    function automatic logic [7:0] pick_row();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(ROWS_DEF - 3, ROWS_DEF - 1));
            default: return 8'($urandom_range(ROWS_DEF - 1));
        endcase
    endfunction

    function automatic logic [7:0] pick_col();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(255));
            1:       return 8'($urandom_range(COLUMNS_DEF - 8, COLUMNS_DEF - 1));
            default: return 8'($urandom_range(COLUMNS_DEF - 1));
        endcase
    endfunction

    // A line of printable text ending in newline; long ones wrap
    task automatic text_line();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(80, 100) : $urandom_range(4, 40);
        repeat (n) send_item(CMD_PUT, 8'($urandom_range(32, 126)), 8'($urandom_range(255)),
                             8'($urandom_range(255)));
        send_item(CMD_PUT, CH_NEWLINE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // One random command; unused fields carry random bytes
    task automatic random_command();
        int         sel;
        logic [7:0] ch;
        logic [7:0] r;
        logic [7:0] c;
        ch  = 8'($urandom_range(255));
        r   = pick_row();
        c   = pick_col();
        sel = $urandom_range(99);
        if (sel < 50) begin
            send_item(CMD_PUT, ch, r, c);
        end else if (sel < 58) begin
            case ($urandom_range(2))
                0:       ch = CH_NEWLINE;
                1:       ch = CH_RETURN;
                default: ch = CH_TAB;
            endcase
            send_item(CMD_PUT, ch, r, c);
        end else if (sel < 70) begin
            send_item(CMD_SET, ch, r, c);
        end else if (sel < 99) begin
            send_item(CMD_READ, ch, r, c);
        end else begin
            send_item(CMD_CLEAR, ch, r, c);
        end
    endtask

    // Main sequence
    initial begin
        int          base;
        bit          paused;
        int          idle_mix  [4];
        int          stall_mix [4];
        logic [7:0]  colors    [4];
        idle_mix  = '{0, 46, 0, 22};
        stall_mix = '{0, 0, 46, 22};
        colors = '{8'hFF, 8'h00, 8'h00, 8'h3C};
        colors[2] = 8'($urandom_range(255));
        sb = new();
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: reset contents, edge bytes, controls, clamping, wrap, scroll
        send_item(CMD_READ, 8'h00, 8'd0, 8'd0);
        send_item(CMD_READ, 8'hFF, 8'd255, 8'd255);
        send_item(CMD_PUT, 8'h41, 8'd0, 8'd0);
        send_item(CMD_PUT, 8'h00, 8'hFF, 8'hFF);
        send_item(CMD_PUT, 8'hFF, 8'h00, 8'h00);
        send_item(CMD_PUT, CH_TAB, 8'd0, 8'd0);
        send_item(CMD_PUT, 8'h7E, 8'd0, 8'd0);
        send_item(CMD_PUT, CH_RETURN, 8'd0, 8'd0);
        send_item(CMD_READ, 8'h00, 8'd0, 8'd2);
        send_item(CMD_PUT, CH_NEWLINE, 8'd0, 8'd0);
        send_item(CMD_SET, 8'h00, 8'd255, 8'd255);
        send_item(CMD_PUT, 8'h5A, 8'd0, 8'd0);           // last cell: wrap and scroll
        send_item(CMD_READ, 8'h00, 8'd23, 8'd79);
        send_item(CMD_SET, 8'h00, 8'd24, 8'd78);
        send_item(CMD_PUT, CH_TAB, 8'd0, 8'd0);          // tab past edge on last row
        send_item(CMD_PUT, CH_NEWLINE, 8'd0, 8'd0);      // newline on last row
        send_item(CMD_SET, 8'h00, 8'd3, 8'd76);
        send_item(CMD_PUT, CH_TAB, 8'd0, 8'd0);          // tab wrap without scroll
        send_item(CMD_SET, 8'h00, 8'd0, 8'd200);
        send_item(CMD_PUT, CH_SPACE, 8'd0, 8'd0);
        send_item(CMD_CLEAR, 8'h00, 8'd0, 8'd0);
        send_item(CMD_READ, 8'h00, 8'd22, 8'd79);
        send_item(CMD_SET, 8'h00, 8'd30, 8'd0);
        send_item(CMD_READ, 8'h00, 8'd0, 8'd0);

        // Random phases, each with its own attribute and idle/stall pattern
        for (int p = 0; p < 4; p++) begin
            drain_results();
            idle_pct  = idle_mix[p];
            stall_pct = stall_mix[p];
            write_color(colors[p]);
            base   = n_sent;
            paused = 1'b0;
            while (n_sent - base < PHASE_QUOTA) begin
                if (!paused && n_sent - base >= PHASE_QUOTA / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                if ($urandom_range(9) == 0) text_line();
                else random_command();
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        $display("Covered %0d commands: %0d put, %0d set, %0d read, %0d clear; %0d scrolls",
                 n_sent, sb.n_puts, sb.n_sets, sb.n_reads, sb.n_clears, sb.n_scrolls);
        $display("%0d attribute writes, %0d results checked, %0d mismatches",
                 sb.n_colors, sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.awaiting.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### text_console_writer.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_sweep.sv
hdl/text_console_writer.sv
dv/tb.sv
